// File: design/sdt_pkg.sv
// Shared types and constants of the sound channel duration tracker.
`timescale 1ns / 1ps
`default_nettype none
package sdt_pkg;

    localparam int CHANNELS = 2;
    localparam int CH_W     = 1;

    localparam int ADDR_W   = 28;
    localparam int COUNT_W  = 24;
    localparam int RATE_W   = 16;
    localparam int VRATE_W  = 16;
    localparam int CLOCK_W  = 25;
    localparam int RELOAD_W = 16;
    localparam int VCNT_W   = 30;
    localparam int PROD_W   = VRATE_W + COUNT_W;
    localparam int DVD_W    = 32;
    localparam int STEP_W   = 5;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 4;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_VBLANK_RATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_CLOCK   = 1'd1;

    localparam logic [VRATE_W-1:0] VRATE_RESET = 16'd15290;
    localparam logic [CLOCK_W-1:0] CLOCK_RESET = 25'd16777216;

    localparam logic [VCNT_W-1:0]   VCNT_MAX  = 30'h3FFF_FFFF;
    localparam logic [RELOAD_W-1:0] TICKS_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        REQ_PLAY    = 3'd0,
        REQ_PAUSE   = 3'd1,
        REQ_UNPAUSE = 3'd2,
        REQ_STOP    = 3'd3,
        REQ_TICK    = 3'd4
    } req_e_t;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_HALT  = 3'd2,
        ACT_TOFF  = 3'd3,
        ACT_TON   = 3'd4
    } act_e_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DUR_GO,
        ST_DUR_WAIT,
        ST_TCK_GO,
        ST_TCK_WAIT,
        ST_OUT_A,
        ST_OUT_B
    } state_e_t;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [RATE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

// File: design/sound_channel_duration_tracker.sv
// Top level: two-channel sound duration tracker in vertical-blank ticks.
//
// Requests enter on the s_axis channel (play, pause all, unpause all, stop
// all, vblank tick). Each request gives two results on m_axis, channel A
// then channel B, the second marked by m_axis_tlast.
// Configuration (vblank rate in 8.8, processor clock) is written through
// cfg_we / cfg_index / cfg_data; the user must write it only while the
// block is idle, as the block itself does not enforce this. A play request
// passes a multiply state and two 32-step passes of the shared divider
// (duration, then timer ticks) before its first result appears. Every
// other request shows its first result in the cycle after acceptance.
// One request is worked at a time: s_axis_tready is high only when no
// result is pending, so a new request waits until both results are taken.
// When the receiver stalls, the result holds on m_axis until taken.
// Synchronous active-low reset clears all channel state, returns the
// configuration to 15290 (8.8) and 16777216 Hz, and leaves the block idle.
`timescale 1ns / 1ps
`default_nettype none
module sound_channel_duration_tracker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [sdt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sdt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // sample_addr[27:0], sample_count[51:28], sample_rate[67:52],
    // repeat_req[68], zero fill [71:69]
    input  wire logic [sdt_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // req_type[2:0], channel[3]
    input  wire logic [sdt_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // start_addr[27:0], timer_reload[43:28], is_playing[44], zero fill [47:45]
    output logic [sdt_pkg::M_TDATA_W-1:0]          m_axis_tdata,
    // out_channel[0], action[3:1]
    output logic [sdt_pkg::M_TUSER_W-1:0]          m_axis_tuser,
    output logic                                   m_axis_tlast
);

    sdt_pkg::state_e_t state_reg, state_next;

    logic [sdt_pkg::VRATE_W-1:0]  vrate_reg, vrate_next;
    logic [sdt_pkg::CLOCK_W-1:0]  clock_reg, clock_next;

    logic                          playing_reg [sdt_pkg::CHANNELS];
    logic                          playing_next [sdt_pkg::CHANNELS];
    logic                          loop_reg [sdt_pkg::CHANNELS];
    logic                          loop_next [sdt_pkg::CHANNELS];
    logic [sdt_pkg::VCNT_W-1:0]    vcnt_reg [sdt_pkg::CHANNELS];
    logic [sdt_pkg::VCNT_W-1:0]    vcnt_next [sdt_pkg::CHANNELS];
    logic [sdt_pkg::VCNT_W-1:0]    vcnt_inc [sdt_pkg::CHANNELS];
    logic [sdt_pkg::VCNT_W-1:0]    dur_reg [sdt_pkg::CHANNELS];
    logic [sdt_pkg::VCNT_W-1:0]    dur_next [sdt_pkg::CHANNELS];
    logic [sdt_pkg::ADDR_W-1:0]    addr_reg [sdt_pkg::CHANNELS];
    logic [sdt_pkg::ADDR_W-1:0]    addr_next [sdt_pkg::CHANNELS];
    logic [sdt_pkg::RELOAD_W-1:0]  reload_reg [sdt_pkg::CHANNELS];
    logic [sdt_pkg::RELOAD_W-1:0]  reload_next [sdt_pkg::CHANNELS];
    sdt_pkg::act_e_t               act_reg [sdt_pkg::CHANNELS];
    sdt_pkg::act_e_t               act_next [sdt_pkg::CHANNELS];

    logic [sdt_pkg::CH_W-1:0]      ch_reg, ch_next;
    logic [sdt_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [sdt_pkg::RATE_W-1:0]    rate_reg, rate_next;
    logic [sdt_pkg::PROD_W-1:0]    prod_reg, prod_next;

    logic [2:0]                    in_req;
    logic [sdt_pkg::CH_W-1:0]      in_ch;
    logic [sdt_pkg::ADDR_W-1:0]    in_addr;
    logic [sdt_pkg::COUNT_W-1:0]   in_count;
    logic [sdt_pkg::RATE_W-1:0]    in_rate;
    logic                          in_rep;
    logic                          in_fire;

    logic [sdt_pkg::VCNT_W-1:0]    dur_val;
    logic [sdt_pkg::RELOAD_W-1:0]  ticks_val;
    logic [sdt_pkg::CH_W-1:0]      osel;
    logic                          ostart;

    sdt_pkg::div_req_t div_req;
    sdt_pkg::div_rsp_t div_rsp;

    assign in_req   = s_axis_tuser[2:0];
    assign in_ch    = s_axis_tuser[3];
    assign in_addr  = s_axis_tdata[27:0];
    assign in_count = s_axis_tdata[51:28];
    assign in_rate  = s_axis_tdata[67:52];
    assign in_rep   = s_axis_tdata[68];
    assign in_fire  = s_axis_tvalid && s_axis_tready;

    sdt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        if (rate_reg == '0) begin
            dur_val = sdt_pkg::VCNT_MAX;
        end else if (|div_rsp.quotient[sdt_pkg::DVD_W-1:sdt_pkg::VCNT_W]) begin
            dur_val = sdt_pkg::VCNT_MAX;
        end else begin
            dur_val = div_rsp.quotient[sdt_pkg::VCNT_W-1:0];
        end
        if (rate_reg == '0) begin
            ticks_val = sdt_pkg::TICKS_MAX;
        end else if (|div_rsp.quotient[sdt_pkg::DVD_W-1:sdt_pkg::RELOAD_W]) begin
            ticks_val = sdt_pkg::TICKS_MAX;
        end else begin
            ticks_val = div_rsp.quotient[sdt_pkg::RELOAD_W-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sdt_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = (in_req == sdt_pkg::REQ_PLAY) ? sdt_pkg::ST_MUL
                                                               : sdt_pkg::ST_OUT_A;
                end
            end
            sdt_pkg::ST_MUL:      state_next = sdt_pkg::ST_DUR_GO;
            sdt_pkg::ST_DUR_GO:   state_next = sdt_pkg::ST_DUR_WAIT;
            sdt_pkg::ST_DUR_WAIT: begin
                if (div_rsp.done) begin
                    state_next = sdt_pkg::ST_TCK_GO;
                end
            end
            sdt_pkg::ST_TCK_GO:   state_next = sdt_pkg::ST_TCK_WAIT;
            sdt_pkg::ST_TCK_WAIT: begin
                if (div_rsp.done) begin
                    state_next = sdt_pkg::ST_OUT_A;
                end
            end
            sdt_pkg::ST_OUT_A: begin
                if (m_axis_tready) begin
                    state_next = sdt_pkg::ST_OUT_B;
                end
            end
            sdt_pkg::ST_OUT_B: begin
                if (m_axis_tready) begin
                    state_next = sdt_pkg::ST_IDLE;
                end
            end
            default: state_next = sdt_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_axis_tready    = 1'b0;
        m_axis_tvalid    = 1'b0;
        div_req.start    = 1'b0;
        div_req.divisor  = rate_reg;
        div_req.dividend = prod_reg[sdt_pkg::PROD_W-1:8];
        case (state_reg)
            sdt_pkg::ST_IDLE:   s_axis_tready = 1'b1;
            sdt_pkg::ST_DUR_GO: div_req.start = 1'b1;
            sdt_pkg::ST_TCK_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = sdt_pkg::DVD_W'(clock_reg);
            end
            sdt_pkg::ST_OUT_A,
            sdt_pkg::ST_OUT_B:  m_axis_tvalid = 1'b1;
            default: ;
        endcase
    end

    // channel state and request data
    always_comb begin
        vrate_next = vrate_reg;
        clock_next = clock_reg;
        ch_next    = ch_reg;
        count_next = count_reg;
        rate_next  = rate_reg;
        prod_next  = prod_reg;
        for (int c = 0; c < sdt_pkg::CHANNELS; c++) begin
            playing_next[c] = playing_reg[c];
            loop_next[c]    = loop_reg[c];
            vcnt_next[c]    = vcnt_reg[c];
            dur_next[c]     = dur_reg[c];
            addr_next[c]    = addr_reg[c];
            reload_next[c]  = reload_reg[c];
            act_next[c]     = act_reg[c];
            vcnt_inc[c]     = (vcnt_reg[c] < sdt_pkg::VCNT_MAX) ? vcnt_reg[c] + 1'b1
                                                                : vcnt_reg[c];
        end

        if (cfg_we) begin
            case (cfg_index)
                sdt_pkg::CFG_VBLANK_RATE: vrate_next = cfg_data[sdt_pkg::VRATE_W-1:0];
                sdt_pkg::CFG_CPU_CLOCK:   clock_next = cfg_data;
                default: ;
            endcase
        end

        if (in_fire) begin
            for (int c = 0; c < sdt_pkg::CHANNELS; c++) begin
                act_next[c] = sdt_pkg::ACT_NONE;
                case (in_req)
                    sdt_pkg::REQ_PLAY: begin
                        if (sdt_pkg::CH_W'(c) == in_ch) begin
                            addr_next[c] = in_addr;
                            loop_next[c] = in_rep;
                            act_next[c]  = sdt_pkg::ACT_START;
                        end
                    end
                    sdt_pkg::REQ_PAUSE: begin
                        playing_next[c] = 1'b0;
                        act_next[c]     = sdt_pkg::ACT_TOFF;
                    end
                    sdt_pkg::REQ_UNPAUSE: begin
                        playing_next[c] = 1'b1;
                        act_next[c]     = sdt_pkg::ACT_TON;
                    end
                    sdt_pkg::REQ_STOP: begin
                        playing_next[c] = 1'b0;
                        act_next[c]     = sdt_pkg::ACT_HALT;
                    end
                    sdt_pkg::REQ_TICK: begin
                        if (playing_reg[c]) begin
                            vcnt_next[c] = vcnt_inc[c];
                            if (vcnt_inc[c] >= dur_reg[c]) begin
                                if (loop_reg[c]) begin
                                    vcnt_next[c] = '0;
                                    act_next[c]  = sdt_pkg::ACT_START;
                                end else begin
                                    playing_next[c] = 1'b0;
                                    act_next[c]     = sdt_pkg::ACT_HALT;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            ch_next    = in_ch;
            count_next = in_count;
            rate_next  = in_rate;
        end

        if (state_reg == sdt_pkg::ST_MUL) begin
            prod_next = vrate_reg * count_reg;
        end

        if (state_reg == sdt_pkg::ST_DUR_WAIT && div_rsp.done) begin
            dur_next[ch_reg] = dur_val;
        end

        if (state_reg == sdt_pkg::ST_TCK_WAIT && div_rsp.done) begin
            reload_next[ch_reg]  = ~ticks_val + 1'b1;
            vcnt_next[ch_reg]    = '0;
            playing_next[ch_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sdt_pkg::ST_IDLE;
            vrate_reg <= sdt_pkg::VRATE_RESET;
            clock_reg <= sdt_pkg::CLOCK_RESET;
            for (int c = 0; c < sdt_pkg::CHANNELS; c++) begin
                playing_reg[c] <= 1'b0;
                loop_reg[c]    <= 1'b0;
                vcnt_reg[c]    <= '0;
                dur_reg[c]     <= '0;
                addr_reg[c]    <= '0;
                reload_reg[c]  <= '0;
                act_reg[c]     <= sdt_pkg::ACT_NONE;
            end
        end else begin
            state_reg <= state_next;
            vrate_reg <= vrate_next;
            clock_reg <= clock_next;
            for (int c = 0; c < sdt_pkg::CHANNELS; c++) begin
                playing_reg[c] <= playing_next[c];
                loop_reg[c]    <= loop_next[c];
                vcnt_reg[c]    <= vcnt_next[c];
                dur_reg[c]     <= dur_next[c];
                addr_reg[c]    <= addr_next[c];
                reload_reg[c]  <= reload_next[c];
                act_reg[c]     <= act_next[c];
            end
        end
        ch_reg    <= ch_next;
        count_reg <= count_next;
        rate_reg  <= rate_next;
        prod_reg  <= prod_next;
    end

    assign osel   = (state_reg == sdt_pkg::ST_OUT_B) ? 1'b1 : 1'b0;
    assign ostart = act_reg[osel] == sdt_pkg::ACT_START;

    assign m_axis_tdata = {3'b000,
                           playing_reg[osel],
                           ostart ? reload_reg[osel] : {sdt_pkg::RELOAD_W{1'b0}},
                           ostart ? addr_reg[osel] : {sdt_pkg::ADDR_W{1'b0}}};
    assign m_axis_tuser = {act_reg[osel], osel};
    assign m_axis_tlast = osel;

    a_ready_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("request taken while a result is pending");

    a_second_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
        else $error("channel B result did not follow channel A");

    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == sdt_pkg::ST_DUR_WAIT ||
                          state_reg == sdt_pkg::ST_TCK_WAIT))
        else $error("divider finished outside a wait state");

    a_start_playing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && ostart |-> playing_reg[osel])
        else $error("start reported on a channel that is not playing");

endmodule
`default_nettype wire

// File: design/sdt_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sdt_div (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire sdt_pkg::div_req_t req,
    output sdt_pkg::div_rsp_t      rsp
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [sdt_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [sdt_pkg::RATE_W-1:0]  rem_reg, rem_next;
    logic [sdt_pkg::RATE_W-1:0]  dsr_reg, dsr_next;
    logic [sdt_pkg::DVD_W-1:0]   quo_reg, quo_next;
    logic [sdt_pkg::RATE_W:0]    trial;
    logic                        fits;

    assign trial = {rem_reg, quo_reg[sdt_pkg::DVD_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dsr_next  = req.divisor;
            quo_next  = req.dividend;
        end else if (busy_reg) begin
            rem_next  = fits ? sdt_pkg::RATE_W'(trial - {1'b0, dsr_reg})
                             : trial[sdt_pkg::RATE_W-1:0];
            quo_next  = {quo_reg[sdt_pkg::DVD_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == sdt_pkg::STEP_W'(sdt_pkg::DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire
